/* design/gspc_pkg.sv */
// ----------------------------------------------------------------------------
// gspc_pkg
// Shared types, sizes and codes of the gain scheduled proportional controller.
// ----------------------------------------------------------------------------
package gspc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int JOINTS      = 6;
   localparam int DATA_W      = 32;
   localparam int SEL_W       = 8;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int JOINT_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int JCOUNT_W    = $clog2(JOINTS + 1);
   localparam int ERR_W       = DATA_W + 1;
   localparam int PROD_W      = DATA_W + ERR_W;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_CAP = 1'b1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_CONTROL = 1'b1;

   localparam logic signed [DATA_W-1:0] SETPOINT_RESET = 32'sd13107;
   localparam logic signed [DATA_W-1:0] GAIN_CAP_RESET = 32'sd655360;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef word_type [JOINTS-1:0] joint_vec_type;

   typedef struct packed {
      logic     command;
      word_type latency_us;
      logic     feedback_valid;
      word_type value_0;
      word_type value_1;
      word_type value_2;
      word_type value_3;
      word_type value_4;
      word_type value_5;
   } req_type;

   typedef struct packed {
      word_type             drive_0;
      word_type             drive_1;
      word_type             drive_2;
      word_type             drive_3;
      word_type             drive_4;
      word_type             drive_5;
      logic [SEL_W-1:0]     selected_index;
      logic                 load_rejected;
      logic                 drive_saturated;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [JOINT_W-1:0] joint;
   } mac_tag_type;

   typedef struct packed {
      logic               valid;
      logic [JOINT_W-1:0] joint;
      word_type           value;
      logic               saturated;
   } mac_result_type;

   function automatic joint_vec_type req_values(input req_type r);
      joint_vec_type v;
      v[0] = r.value_0;
      v[1] = r.value_1;
      v[2] = r.value_2;
      v[3] = r.value_3;
      v[4] = r.value_4;
      v[5] = r.value_5;
      return v;
   endfunction

   function automatic rsp_type pack_rsp(input joint_vec_type d,
                                        input logic [SEL_W-1:0] sel,
                                        input logic rej,
                                        input logic sat);
      rsp_type r;
      r.drive_0         = d[0];
      r.drive_1         = d[1];
      r.drive_2         = d[2];
      r.drive_3         = d[3];
      r.drive_4         = d[4];
      r.drive_5         = d[5];
      r.selected_index  = sel;
      r.load_rejected   = rej;
      r.drive_saturated = sat;
      return r;
   endfunction

endpackage

/* design/gspc_table.sv */
// ----------------------------------------------------------------------------
// gspc_table
// Schedule table: latency keys and gain rows, one write and one registered read.
// ----------------------------------------------------------------------------
module gspc_table import gspc_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  word_type          wr_key,
   input  joint_vec_type     wr_gains,
   input  logic [ADDR_W-1:0] rd_addr,
   output word_type          rd_key,
   output joint_vec_type     rd_gains
);

   word_type      key_mem  [TABLE_DEPTH];
   joint_vec_type gain_mem [TABLE_DEPTH];
   word_type      rd_key_ff;
   joint_vec_type rd_gains_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         gain_mem[wr_addr] <= wr_gains;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_gains_ff <= gain_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_gains = rd_gains_ff;

endmodule

/* design/gspc_mac.sv */
// ----------------------------------------------------------------------------
// gspc_mac
// Two-stage drive unit: cap the gain, multiply by the error, floor and clip.
// ----------------------------------------------------------------------------
module gspc_mac import gspc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mac_tag_type    op,
   input  word_type       gain,
   input  word_type       gain_cap,
   input  word_type       setpoint,
   input  word_type       position,
   output mac_result_type result
);

   localparam int SHIFT_W = PROD_W - FRAC_W;

   word_type                    gain_capped;
   logic signed [ERR_W-1:0]     err;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    prod_ff;
   mac_tag_type                 tag_ff;
   logic [SHIFT_W-1:0]          shifted;
   logic [SHIFT_W-DATA_W:0]     high_bits;
   logic                        clip;
   mac_result_type              result_in;
   mac_result_type              result_ff;

   always_comb begin
      gain_capped = (gain > gain_cap) ? gain_cap : gain;
      err         = ERR_W'(setpoint) - ERR_W'(position);
      prod_in     = gain_capped * err;
   end

   // floor shift, then clip when the upper bits are not a sign extension
   always_comb begin
      shifted   = prod_ff[PROD_W-1:FRAC_W];
      high_bits = shifted[SHIFT_W-1:DATA_W-1];
      clip      = !((&high_bits) || !(|high_bits));
      result_in.valid     = tag_ff.valid;
      result_in.joint     = tag_ff.joint;
      result_in.saturated = clip;
      if (!clip) begin
         result_in.value = shifted[DATA_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         result_in.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         result_in.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         tag_ff          <= '0;
         result_ff.valid <= 1'b0;
      end else begin
         tag_ff          <= op;
         result_ff.valid <= result_in.valid;
      end
      result_ff.joint     <= result_in.joint;
      result_ff.value     <= result_in.value;
      result_ff.saturated <= result_in.saturated;
   end

   assign result = result_ff;

endmodule

/* design/gain_scheduled_p_controller.sv */
// ----------------------------------------------------------------------------
// gain_scheduled_p_controller
// Six-joint proportional controller with a latency-scheduled gain table.
// ----------------------------------------------------------------------------
// A load word (command 0) appends one row (latency key and six gains) to the
// table; with the table full the row is dropped and load_rejected is set.
// A control word (command 1) scans all N loaded keys, one memory read per
// cycle, for the key nearest latency_us (lowest row wins a tie), reads that
// gain row, then runs the six joints through one shared multiplier.
// A load word, or a control word with feedback invalid or the table empty,
// goes straight to the output register with no scan and no multiply; any
// other control word takes longer as N grows, as the key scan over the
// table memory reads every loaded row.
// One word is in work at a time: req_stall is high from acceptance until
// the result is moved into the output register. The output register holds
// a result while rsp_stall is high, and the next request word is accepted
// meanwhile; it completes its work and then waits for the register.
// Reset (synchronous) empties the table and restores setpoint 0.2 and gain
// cap 10.0; table memory contents are not cleared. csr writes are always
// taken, and belong only in idle periods.
// ----------------------------------------------------------------------------
module gain_scheduled_p_controller import gspc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  word_type               csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ROW_READ,
      ST_MULT,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   word_type             setpoint_ff, setpoint_in;
   word_type             gain_cap_ff, gain_cap_in;
   logic [COUNT_W-1:0]   issue_ff, issue_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [ADDR_W-1:0]    best_idx_ff, best_idx_in;
   logic [DATA_W-1:0]    best_diff_ff, best_diff_in;
   logic                 best_found_ff, best_found_in;
   logic [JCOUNT_W-1:0]  joint_ff, joint_in;
   joint_vec_type        drive_ff, drive_in;
   logic                 sat_ff, sat_in;
   logic                 rej_ff, rej_in;
   logic [ADDR_W-1:0]    sel_ff, sel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   word_type             rd_key;
   joint_vec_type        rd_gains;
   joint_vec_type        positions;
   logic signed [ERR_W-1:0] key_diff;
   logic [ERR_W-1:0]     key_mag;
   mac_tag_type          mac_op;
   mac_result_type       mac_result;
   logic [JOINT_W-1:0]   mac_joint;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign positions  = req_values(req_ff);
   assign mac_joint  = joint_ff[JOINT_W-1:0];

   assign wr_en   = req_accept && (req_data.command == CMD_LOAD) &&
                    (count_ff != COUNT_W'(TABLE_DEPTH));
   assign rd_addr = (state_ff == ST_SCAN) ? issue_ff[ADDR_W-1:0] : best_idx_ff;

   gspc_table u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[ADDR_W-1:0]),
      .wr_key   (req_data.latency_us),
      .wr_gains (req_values(req_data)),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_gains (rd_gains)
   );

   assign mac_op.valid = (state_ff == ST_MULT) && (joint_ff < JCOUNT_W'(JOINTS));
   assign mac_op.joint = mac_joint;

   gspc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .op       (mac_op),
      .gain     (rd_gains[mac_joint]),
      .gain_cap (gain_cap_ff),
      .setpoint (setpoint_ff),
      .position (positions[mac_joint]),
      .result   (mac_result)
   );

   always_comb begin
      key_diff = ERR_W'(req_ff.latency_us) - ERR_W'(rd_key);
      key_mag  = key_diff[ERR_W-1] ? ERR_W'(-key_diff) : ERR_W'(key_diff);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      setpoint_in   = setpoint_ff;
      gain_cap_in   = gain_cap_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = issue_ff[ADDR_W-1:0];
      best_idx_in   = best_idx_ff;
      best_diff_in  = best_diff_ff;
      best_found_in = best_found_ff;
      joint_in      = joint_ff;
      drive_in      = drive_ff;
      sat_in        = sat_ff;
      rej_in        = rej_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SETPOINT: setpoint_in = csr_data;
            CSR_GAIN_CAP: gain_cap_in = csr_data;
            default: ;
         endcase
      end

      // nearest key compare, one row behind the read
      if (cmp_valid_ff && (!best_found_ff || (key_mag[DATA_W-1:0] < best_diff_ff))) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_diff_in  = key_mag[DATA_W-1:0];
      end

      if (mac_result.valid) begin
         drive_in[mac_result.joint] = mac_result.value;
         sat_in = sat_ff || mac_result.saturated;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               drive_in = '0;
               sat_in   = 1'b0;
               rej_in   = 1'b0;
               sel_in   = '0;
               state_in = ST_DONE;
               if (req_data.command == CMD_LOAD) begin
                  if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                     rej_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (req_data.feedback_valid && (count_ff != '0)) begin
                  issue_in      = '0;
                  best_found_in = 1'b0;
                  best_idx_in   = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end else begin
               state_in = ST_ROW_READ;
            end
         end
         ST_ROW_READ: begin
            sel_in   = best_idx_ff;
            joint_in = '0;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            if (mac_op.valid) begin
               joint_in = joint_ff + 1'b1;
            end
            if (mac_result.valid && (mac_result.joint == JOINT_W'(JOINTS - 1))) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pack_rsp(drive_ff, SEL_W'(sel_ff), rej_ff, sat_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         setpoint_ff   <= SETPOINT_RESET;
         gain_cap_ff   <= GAIN_CAP_RESET;
         cmp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         setpoint_ff   <= setpoint_in;
         gain_cap_ff   <= gain_cap_in;
         cmp_valid_ff  <= cmp_valid_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff       <= req_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_diff_ff <= best_diff_in;
      joint_ff     <= joint_in;
      drive_ff     <= drive_in;
      sat_ff       <= sat_in;
      rej_ff       <= rej_in;
      sel_ff       <= sel_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("row count beyond table depth");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.load_rejected) |-> (count_ff == COUNT_W'(TABLE_DEPTH)))
      else $error("load rejected while table not full");

   a_best_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> (COUNT_W'(best_idx_ff) < count_ff))
      else $error("selected row not loaded");

   a_mac_in_mult: assert property (@(posedge clock) disable iff (reset)
      mac_result.valid |-> (state_ff == ST_MULT))
      else $error("drive result outside multiply phase");

endmodule
